/* design/isq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package isq_pkg;

    localparam int CAPACITY    = 16;
    localparam int OCC_W       = $clog2(CAPACITY + 1);
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int POS_W       = 6;
    localparam int VAL_W       = 32;
    localparam int COUNT_W     = 5;
    localparam int CMP_W       = ((OCC_W > POS_W) ? OCC_W : POS_W) + 1;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        REQ_PUSH_BACK,
        REQ_PUSH_FRONT,
        REQ_INSERT_AT,
        REQ_DELETE_AT,
        REQ_POP_BACK,
        REQ_POP_FRONT,
        REQ_REVERSE,
        REQ_DUMP
    } req_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_RANGE,
        ST_FULL,
        ST_EMPTY
    } status_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_INSERT,
        OP_DELETE,
        OP_REVERSE,
        OP_DUMP
    } op_t;

    // decoded request: checks already done, occ is the count after the request
    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] pos;
        logic [VAL_W-1:0] value;
        status_t          status;
        logic [OCC_W-1:0] occ;
    } cmd_t;

endpackage

`default_nettype wire

/* design/isq_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module isq_front
    import isq_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire logic [2:0]       req_type,
    input  wire logic [POS_W-1:0] position,
    input  wire logic [VAL_W-1:0] item_value,
    output cmd_t                  cmd
);

    // count as it stands after every accepted request
    logic [OCC_W-1:0] occ_reg;
    req_t             req;
    logic [CMP_W-1:0] occ_x;
    logic [CMP_W-1:0] pos_x;
    logic [CMP_W-1:0] ins_pos_x;
    logic [CMP_W-1:0] tail_x;

    assign req    = req_t'(req_type);
    assign occ_x  = CMP_W'(occ_reg);
    assign pos_x  = CMP_W'(position);
    assign tail_x = occ_x - 1'b1;

    always_comb
    begin
        cmd.op     = OP_NONE;
        cmd.pos    = '0;
        cmd.value  = item_value;
        cmd.status = ST_OK;
        cmd.occ    = occ_reg;
        ins_pos_x  = pos_x;

        unique case (req) inside
            REQ_PUSH_BACK, REQ_PUSH_FRONT, REQ_INSERT_AT:
            begin
                if (req == REQ_PUSH_BACK)
                begin
                    ins_pos_x = occ_x;
                end
                else if (req == REQ_PUSH_FRONT)
                begin
                    ins_pos_x = '0;
                end
                // range check ranks ahead of the full check
                if (ins_pos_x > occ_x)
                begin
                    cmd.status = ST_RANGE;
                end
                else if (occ_x >= CMP_W'(CAPACITY))
                begin
                    cmd.status = ST_FULL;
                end
                else
                begin
                    cmd.op  = OP_INSERT;
                    cmd.pos = ins_pos_x[IDX_W-1:0];
                    cmd.occ = occ_reg + 1'b1;
                end
            end
            REQ_DELETE_AT:
            begin
                if (pos_x >= occ_x)
                begin
                    cmd.status = ST_RANGE;
                end
                else
                begin
                    cmd.op  = OP_DELETE;
                    cmd.pos = pos_x[IDX_W-1:0];
                    cmd.occ = occ_reg - 1'b1;
                end
            end
            REQ_POP_BACK, REQ_POP_FRONT:
            begin
                if (occ_reg == '0)
                begin
                    cmd.status = ST_EMPTY;
                end
                else
                begin
                    cmd.op  = OP_DELETE;
                    cmd.pos = (req == REQ_POP_BACK) ? tail_x[IDX_W-1:0] : '0;
                    cmd.occ = occ_reg - 1'b1;
                end
            end
            REQ_REVERSE:
            begin
                cmd.op = OP_REVERSE;
            end
            default:
            begin
                cmd.op = OP_DUMP;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else if (accept)
        begin
            occ_reg <= cmd.occ;
        end
    end

endmodule

`default_nettype wire

/* design/isq_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module isq_queue
    import isq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t wr_cmd,
    input  wire logic pop,
    output logic      full,
    output logic      not_empty,
    output cmd_t      rd_cmd
);

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;

    assign full      = (fill_reg == FILL_W'(QUEUE_DEPTH));
    assign not_empty = (fill_reg != '0);
    assign rd_cmd    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

`default_nettype wire

/* design/isq_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module isq_back
    import isq_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    input  wire cmd_t               cmd,
    output logic                    pop,
    output logic                    done,
    output logic [1:0]              status,
    output logic [COUNT_W-1:0]      count,
    output logic [VAL_W-1:0]        element,
    output logic                    last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_REVERSE,
        S_DUMP
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [IDX_W-1:0]   step_reg;
    logic [IDX_W-1:0]   step_next;
    logic [IDX_W-1:0]   limit_reg;
    logic [IDX_W-1:0]   limit_next;
    logic [OCC_W-1:0]   occ_reg;
    logic [OCC_W-1:0]   occ_next;
    logic [OCC_W-1:0]   occ_less;
    logic [VAL_W-1:0]   cell_reg  [CAPACITY];
    logic [VAL_W-1:0]   cell_next [CAPACITY];
    logic [VAL_W-1:0]   pick;
    logic               done_reg;
    logic               done_next;
    status_t            status_reg;
    status_t            status_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [VAL_W-1:0]   element_reg;
    logic [VAL_W-1:0]   element_next;
    logic               last_reg;
    logic               last_next;

    assign done    = done_reg;
    assign status  = status_reg;
    assign count   = count_reg;
    assign element = element_reg;
    assign last    = last_reg;

    // one read port on the cell row: dump output and the reverse front pick
    assign pick     = cell_reg[step_reg];
    assign occ_less = cmd.occ - 1'b1;

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        limit_next   = limit_reg;
        occ_next     = occ_reg;
        cell_next    = cell_reg;
        pop          = 1'b0;
        done_next    = 1'b0;
        status_next  = ST_OK;
        count_next   = '0;
        element_next = '0;
        last_next    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    pop         = 1'b1;
                    occ_next    = cmd.occ;
                    done_next   = 1'b1;
                    status_next = cmd.status;
                    count_next  = COUNT_W'(cmd.occ);
                    last_next   = 1'b1;
                    case (cmd.op)
                        OP_INSERT:
                        begin
                            if (cmd.pos == '0)
                            begin
                                cell_next[0] = cmd.value;
                            end
                            for (int i = 1; i < CAPACITY; i++)
                            begin
                                if (IDX_W'(i) > cmd.pos)
                                begin
                                    cell_next[i] = cell_reg[i-1];
                                end
                                else if (IDX_W'(i) == cmd.pos)
                                begin
                                    cell_next[i] = cmd.value;
                                end
                            end
                        end
                        OP_DELETE:
                        begin
                            for (int i = 0; i < CAPACITY - 1; i++)
                            begin
                                if (IDX_W'(i) >= cmd.pos)
                                begin
                                    cell_next[i] = cell_reg[i+1];
                                end
                            end
                        end
                        OP_REVERSE:
                        begin
                            // step k moves entry k to the front, k = 1 .. count-1
                            if (cmd.occ > OCC_W'(1))
                            begin
                                state_next = S_REVERSE;
                                step_next  = IDX_W'(1);
                                limit_next = occ_less[IDX_W-1:0];
                            end
                        end
                        OP_DUMP:
                        begin
                            if (cmd.occ != '0)
                            begin
                                done_next  = 1'b0;
                                last_next  = 1'b0;
                                state_next = S_DUMP;
                                step_next  = '0;
                                limit_next = occ_less[IDX_W-1:0];
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_REVERSE:
            begin
                cell_next[0] = pick;
                for (int i = 1; i < CAPACITY; i++)
                begin
                    if (IDX_W'(i) <= step_reg)
                    begin
                        cell_next[i] = cell_reg[i-1];
                    end
                end
                if (step_reg == limit_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_DUMP:
            begin
                done_next    = 1'b1;
                count_next   = COUNT_W'(occ_reg);
                element_next = pick;
                if (step_reg == limit_reg)
                begin
                    last_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            step_reg    <= '0;
            limit_reg   <= '0;
            occ_reg     <= '0;
            done_reg    <= 1'b0;
            status_reg  <= ST_OK;
            count_reg   <= '0;
            element_reg <= '0;
            last_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            limit_reg   <= limit_next;
            occ_reg     <= occ_next;
            done_reg    <= done_next;
            status_reg  <= status_next;
            count_reg   <= count_next;
            element_reg <= element_next;
            last_reg    <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
    end

endmodule

`default_nettype wire

/* design/indexed_sequence_store.sv */
// A request accepted at a clock edge is written into the command queue; the back end then
// pops it and registers its result. A dump of a non-empty store first enters its dump state.
// An edit is applied in the back end's idle state; a reverse then moves each entry after the
// first to the front in turn; a dump gives one result per element (an empty dump gives one).
// A two-entry command queue lets requests be taken while the back end works.
// Reset clears the count and the queue; element contents stay undefined until written.
// The receiver cannot stall: each result shows for one cycle with done high.
`timescale 1ns / 1ps
`default_nettype none

module indexed_sequence_store
    import isq_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [2:0]          req_type,
    input  wire logic [POS_W-1:0]    position,
    input  wire logic signed [31:0]  item_value,
    output logic                     done,
    output logic [1:0]               status,
    output logic [COUNT_W-1:0]       count,
    output logic signed [31:0]       element,
    output logic                     last
);

    logic             accept;
    logic             q_full;
    logic             q_not_empty;
    logic             q_pop;
    cmd_t             front_cmd;
    cmd_t             head_cmd;
    logic [VAL_W-1:0] element_raw;

    assign busy    = q_full;
    assign accept  = start && !busy;
    assign element = element_raw;

    isq_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .req_type   (req_type),
        .position   (position),
        .item_value (item_value),
        .cmd        (front_cmd)
    );

    isq_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .wr_cmd    (front_cmd),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .rd_cmd    (head_cmd)
    );

    isq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_not_empty),
        .cmd       (head_cmd),
        .pop       (q_pop),
        .done      (done),
        .status    (status),
        .count     (count),
        .element   (element_raw),
        .last      (last)
    );

endmodule

`default_nettype wire

/* design/isq_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module isq_checker
    import isq_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               done,
    input wire logic [1:0]         status,
    input wire logic [COUNT_W-1:0] count,
    input wire logic [31:0]        element,
    input wire logic               last
);

    // a dump streams its elements with no gaps and no status change
    a_dump_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        done && !last |=> done && status == ST_OK)
        else $error("dump stream broken");

    a_dump_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        done && !last |=> count == $past(count))
        else $error("count changed during dump");

    a_reject_single: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_OK |-> last && element == '0)
        else $error("rejected request gave a multi-part or nonzero result");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_FULL |-> count == COUNT_W'(CAPACITY))
        else $error("full reported below capacity");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> !last)
        else $error("last without a result");

endmodule

bind indexed_sequence_store isq_checker u_isq_checker (.*);

`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
    import isq_pkg::*;

    typedef struct packed {
        status_t                status;
        logic [COUNT_W-1:0]     count;
        logic signed [VAL_W-1:0] element;
        logic                   last;
    } result_t;

    typedef struct packed {
        req_t                   req;
        logic [POS_W-1:0]       pos;
        logic [VAL_W-1:0]       val;
        logic [4:0]             reps;   // >1: row repeated with fresh random values
        logic                   typed;  // expected result written in the row
        status_t                st;
        logic [COUNT_W-1:0]     cnt;
    } dir_row_t;

    localparam int N_DIR    = 29;
    localparam int N_RANDOM = 388;

    localparam dir_row_t DIR_TAB [N_DIR] = '{
        '{REQ_POP_BACK,   6'd0,  32'h0000_0000, 5'd1,  1'b1, ST_EMPTY, 5'd0},
        '{REQ_POP_FRONT,  6'd0,  32'h0000_0000, 5'd1,  1'b1, ST_EMPTY, 5'd0},
        '{REQ_DELETE_AT,  6'd0,  32'h0000_0000, 5'd1,  1'b1, ST_RANGE, 5'd0},
        '{REQ_INSERT_AT,  6'd1,  32'h1234_5678, 5'd1,  1'b1, ST_RANGE, 5'd0},
        '{REQ_DUMP,       6'd0,  32'h0000_0000, 5'd1,  1'b1, ST_OK,    5'd0},
        '{REQ_REVERSE,    6'd63, 32'hFFFF_FFFF, 5'd1,  1'b1, ST_OK,    5'd0},
        '{REQ_PUSH_BACK,  6'd0,  32'h7FFF_FFFF, 5'd1,  1'b1, ST_OK,    5'd1},
        '{REQ_POP_BACK,   6'd0,  32'h0000_0000, 5'd1,  1'b1, ST_OK,    5'd0},
        '{REQ_PUSH_FRONT, 6'd0,  32'h8000_0000, 5'd1,  1'b1, ST_OK,    5'd1},
        '{REQ_REVERSE,    6'd0,  32'h0000_0000, 5'd1,  1'b1, ST_OK,    5'd1},
        '{REQ_POP_FRONT,  6'd0,  32'h0000_0000, 5'd1,  1'b1, ST_OK,    5'd0},
        '{REQ_PUSH_FRONT, 6'd0,  32'hFFFF_FFFF, 5'd1,  1'b1, ST_OK,    5'd1},
        '{REQ_INSERT_AT,  6'd1,  32'h5555_5555, 5'd1,  1'b1, ST_OK,    5'd2},
        '{REQ_INSERT_AT,  6'd0,  32'hAAAA_AAAA, 5'd1,  1'b1, ST_OK,    5'd3},
        '{REQ_INSERT_AT,  6'd63, 32'h0000_0001, 5'd1,  1'b1, ST_RANGE, 5'd3},
        '{REQ_DUMP,       6'd0,  32'h0000_0000, 5'd1,  1'b0, ST_OK,    5'd0},
        '{REQ_REVERSE,    6'd0,  32'h0000_0000, 5'd1,  1'b1, ST_OK,    5'd3},
        '{REQ_DUMP,       6'd0,  32'h0000_0000, 5'd1,  1'b0, ST_OK,    5'd0},
        '{REQ_DELETE_AT,  6'd3,  32'h0000_0000, 5'd1,  1'b1, ST_RANGE, 5'd3},
        '{REQ_DELETE_AT,  6'd1,  32'h0000_0000, 5'd1,  1'b1, ST_OK,    5'd2},
        '{REQ_PUSH_BACK,  6'd0,  32'h0000_0000, 5'd14, 1'b0, ST_OK,    5'd0},
        '{REQ_PUSH_BACK,  6'd0,  32'h0BAD_F00D, 5'd1,  1'b1, ST_FULL,  5'd16},
        '{REQ_PUSH_FRONT, 6'd0,  32'h0BAD_F00D, 5'd1,  1'b1, ST_FULL,  5'd16},
        '{REQ_INSERT_AT,  6'd16, 32'h0BAD_F00D, 5'd1,  1'b1, ST_FULL,  5'd16},
        '{REQ_INSERT_AT,  6'd17, 32'h0BAD_F00D, 5'd1,  1'b1, ST_RANGE, 5'd16},
        '{REQ_DUMP,       6'd0,  32'h0000_0000, 5'd1,  1'b0, ST_OK,    5'd0},
        '{REQ_DELETE_AT,  6'd15, 32'h0000_0000, 5'd1,  1'b1, ST_OK,    5'd15},
        '{REQ_REVERSE,    6'd0,  32'h0000_0000, 5'd1,  1'b1, ST_OK,    5'd15},
        '{REQ_DUMP,       6'd0,  32'h0000_0000, 5'd1,  1'b0, ST_OK,    5'd0}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic [2:0]             req_type;
    logic [POS_W-1:0]       position;
    logic signed [VAL_W-1:0] item_value;
    logic                   done;
    logic [1:0]             status;
    logic [COUNT_W-1:0]     count;
    logic signed [VAL_W-1:0] element;
    logic                   last;

    // predicted contents of the store, front at index 0
    logic [VAL_W-1:0]       seq_vals [CAPACITY];
    int                     seq_len;

    result_t                staged [$];
    result_t                pending_results [$];

    int errors;
    int n_requests;
    int n_checked;
    int n_dumped;
    int n_full;
    int n_range;
    int n_empty;
    int burst_left;

    indexed_sequence_store u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .position   (position),
        .item_value (item_value),
        .done       (done),
        .status     (status),
        .count      (count),
        .element    (element),
        .last       (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic status_t place_at(input int pos, input logic [VAL_W-1:0] val);
        int i;
        if (pos > seq_len)
            return ST_RANGE;
        if (seq_len >= CAPACITY)
            return ST_FULL;
        for (i = seq_len; i > pos; i--)
            seq_vals[i] = seq_vals[i-1];
        seq_vals[pos] = val;
        seq_len++;
        return ST_OK;
    endfunction

    function automatic status_t drop_at(input int pos);
        int i;
        if (pos >= seq_len)
            return ST_RANGE;
        for (i = pos; i + 1 < seq_len; i++)
            seq_vals[i] = seq_vals[i+1];
        seq_len--;
        return ST_OK;
    endfunction

    // apply one request to the predicted store; results land in staged
    task automatic store_request(input req_t r, input logic [POS_W-1:0] p,
                                 input logic [VAL_W-1:0] v);
        status_t          st;
        int               i;
        logic [VAL_W-1:0] t;
        staged.delete();
        st = ST_OK;
        case (r)
            REQ_PUSH_BACK:  st = place_at(seq_len, v);
            REQ_PUSH_FRONT: st = place_at(0, v);
            REQ_INSERT_AT:  st = place_at(int'(p), v);
            REQ_DELETE_AT:  st = drop_at(int'(p));
            REQ_POP_BACK:
            begin
                if (seq_len == 0)
                    st = ST_EMPTY;
                else
                    st = drop_at(seq_len - 1);
            end
            REQ_POP_FRONT:
            begin
                if (seq_len == 0)
                    st = ST_EMPTY;
                else
                    st = drop_at(0);
            end
            REQ_REVERSE:
            begin
                for (i = 0; i < seq_len / 2; i++)
                begin
                    t = seq_vals[i];
                    seq_vals[i] = seq_vals[seq_len-1-i];
                    seq_vals[seq_len-1-i] = t;
                end
            end
            default: ;
        endcase
        if (r == REQ_DUMP)
        begin
            if (seq_len == 0)
                staged.push_back('{ST_OK, COUNT_W'(0), 32'sd0, 1'b1});
            for (i = 0; i < seq_len; i++)
            begin
                staged.push_back('{ST_OK, COUNT_W'(seq_len), seq_vals[i], i == seq_len - 1});
                n_dumped++;
            end
        end
        else
        begin
            staged.push_back('{st, COUNT_W'(seq_len), 32'sd0, 1'b1});
            if (st == ST_FULL)
                n_full++;
            if (st == ST_RANGE)
                n_range++;
            if (st == ST_EMPTY)
                n_empty++;
        end
    endtask

    // sender pacing: bursts of back-to-back requests with random gaps between
    task automatic pace();
        int gap;
        burst_left--;
        if (burst_left <= 0)
        begin
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 9);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(9) == 0) ? 60 : $urandom_range(1, 24);
        end
    endtask

    task automatic issue(input req_t r, input logic [POS_W-1:0] p, input logic [VAL_W-1:0] v,
                         input logic typed, input status_t st, input logic [COUNT_W-1:0] cnt);
        int i;
        start      <= 1'b1;
        req_type   <= r;
        position   <= p;
        item_value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        store_request(r, p, v);
        if (typed)
            pending_results.push_back('{st, cnt, 32'sd0, 1'b1});
        else
            for (i = 0; i < staged.size(); i++)
                pending_results.push_back(staged[i]);
        n_requests++;
        pace();
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(15))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    // result checker: done marks a result that must be taken this cycle
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && done)
        begin
            got = '{status_t'(status), count, element, last};
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= 200)
                    $display("%0t: unexpected result status=%0d count=%0d element=%0d last=%0d",
                             $time, status, count, element, last);
            end
            else
            begin
                want = pending_results.pop_front();
                n_checked++;
                if (got.status !== want.status || got.count !== want.count ||
                    got.element !== want.element || got.last !== want.last)
                begin
                    errors++;
                    // cap the log on a badly broken design
                    if (errors <= 200)
                        $display({"%0t: mismatch expected status=%0d count=%0d element=%0d ",
                                  "last=%0d, actual status=%0d count=%0d element=%0d last=%0d"},
                                 $time, want.status, want.count, want.element, want.last,
                                 got.status, got.count, got.element, got.last);
                end
            end
        end
    end

    initial
    begin
        int               k;
        int               rep;
        int               sel;
        bit               fill_mode;
        req_t             rq;
        logic [POS_W-1:0] p;
        logic [VAL_W-1:0] v;

        rst_n      = 1'b0;
        start      = 1'b0;
        req_type   = '0;
        position   = '0;
        item_value = '0;
        errors     = 0;
        n_requests = 0;
        n_checked  = 0;
        n_dumped   = 0;
        n_full     = 0;
        n_range    = 0;
        n_empty    = 0;
        seq_len    = 0;
        fill_mode  = 1'b1;
        for (k = 0; k < CAPACITY; k++)
            seq_vals[k] = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        burst_left = $urandom_range(1, 12);

        for (k = 0; k < N_DIR; k++)
        begin
            for (rep = 0; rep < DIR_TAB[k].reps; rep++)
            begin
                v = (DIR_TAB[k].reps > 1) ? pick_value() : DIR_TAB[k].val;
                issue(DIR_TAB[k].req, DIR_TAB[k].pos, v,
                      DIR_TAB[k].typed, DIR_TAB[k].st, DIR_TAB[k].cnt);
            end
        end

        for (k = 0; k < N_RANDOM; k++)
        begin
            // phases that grow or drain the store, picked at random every 40 requests
            if ((k % 40) == 0)
                fill_mode = 1'($urandom_range(1));
            sel = $urandom_range(99);
            if (fill_mode)
            begin
                if (sel < 24)      rq = REQ_PUSH_BACK;
                else if (sel < 42) rq = REQ_PUSH_FRONT;
                else if (sel < 66) rq = REQ_INSERT_AT;
                else if (sel < 74) rq = REQ_DELETE_AT;
                else if (sel < 80) rq = REQ_POP_BACK;
                else if (sel < 86) rq = REQ_POP_FRONT;
                else if (sel < 92) rq = REQ_REVERSE;
                else               rq = REQ_DUMP;
            end
            else
            begin
                if (sel < 8)       rq = REQ_PUSH_BACK;
                else if (sel < 15) rq = REQ_PUSH_FRONT;
                else if (sel < 25) rq = REQ_INSERT_AT;
                else if (sel < 48) rq = REQ_DELETE_AT;
                else if (sel < 63) rq = REQ_POP_BACK;
                else if (sel < 78) rq = REQ_POP_FRONT;
                else if (sel < 86) rq = REQ_REVERSE;
                else               rq = REQ_DUMP;
            end
            p = POS_W'($urandom_range(63));
            if (rq == REQ_INSERT_AT && $urandom_range(9) < 8)
                p = POS_W'($urandom_range(seq_len));
            if (rq == REQ_DELETE_AT && seq_len > 0 && $urandom_range(9) < 8)
                p = POS_W'($urandom_range(seq_len - 1));
            v = pick_value();
            issue(rq, p, v, 1'b0, ST_OK, '0);
        end

        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Ran %0d requests, checked %0d results, %0d of them dumped elements.",
                 n_requests, n_checked, n_dumped);
        $display("Rejections seen: %0d full, %0d out of range, %0d empty pops.",
                 n_full, n_range, n_empty);
        if (errors == 0)
            $display("PASS indexed_sequence_store");
        else
            $display("FAIL indexed_sequence_store");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("FAIL indexed_sequence_store");
        $finish;
    end

endmodule

/* indexed_sequence_store.f */
design/isq_pkg.sv
design/isq_front.sv
design/isq_queue.sv
design/isq_back.sv
design/indexed_sequence_store.sv
design/isq_checker.sv
tb/sv/tb.sv
